>>> hdl/ktt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_pkg: shared types and codes of the keyed timeout table
// Item kinds, result status codes and the command beat passed from the
// front end to the table engine.
// ----------------------------------------------------------------------------
package ktt_pkg;

  localparam int IdW   = 16;
  localparam int DelayW = 32;
  localparam int TimeW = 48;

  // Item kinds.
  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_FIRED     = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Command handed from the front end to the engine.
  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] now;
  } cmd_t;

endpackage

>>> hdl/ktt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_ifs: channel interfaces of the keyed timeout table
// Input item channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface ktt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] timer_id;
  logic [31:0] delay_ms;
  logic [47:0] now_ms;

  modport source (output valid, kind, timer_id, delay_ms, now_ms, input ready);
  modport sink (input valid, kind, timer_id, delay_ms, now_ms, output ready);
endinterface

interface ktt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fired_id;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, fired_id, status, last, input ready);
  modport sink (input valid, fired_id, status, last, output ready);
endinterface

>>> hdl/ktt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_front: item intake and command queue
// Accepts input beats, computes the saturated deadline and queues the
// command in a two-entry queue ahead of the table engine.
// ----------------------------------------------------------------------------
module ktt_front
  import ktt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [IdW-1:0]    in_timer_id,
  input  logic [DelayW-1:0] in_delay_ms,
  input  logic [TimeW-1:0]  in_now_ms,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [TimeW:0] sum;
  cmd_t       new_cmd;
  logic       push, pop;

  // Deadline is now plus delay, pinned at the top of the time range.
  always_comb begin
    sum = {1'b0, in_now_ms} + {{(TimeW + 1 - DelayW){1'b0}}, in_delay_ms};
    new_cmd.kind     = in_kind;
    new_cmd.id       = in_timer_id;
    new_cmd.deadline = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    new_cmd.now      = in_now_ms;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Queue pointers and fill level.
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

endmodule

>>> hdl/ktt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktt_engine: timeout table engine
// Holds the compacted table in memories, scans and compacts it one entry a
// cycle, and drives the registered result channel.
// ----------------------------------------------------------------------------
module ktt_engine
  import ktt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IdW-1:0]   out_fired_id,
  output logic [2:0]       out_status,
  output logic             out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DOUT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    wp_r, wp_nxt;
  logic [CW-1:0]    sp_r, sp_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt;

  logic [IdW-1:0]   id_mem   [TABLE_DEPTH];
  logic [TimeW-1:0] dl_mem   [TABLE_DEPTH];
  logic [IdW-1:0]   fire_mem [TABLE_DEPTH];
  logic [IdW-1:0]   rd_id_r;
  logic [TimeW-1:0] rd_dl_r;
  logic [IdW-1:0]   fire_rd_r;

  logic             out_valid_r, out_valid_nxt;
  logic [IdW-1:0]   out_id_r, out_id_nxt;
  logic [2:0]       out_st_r, out_st_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             issue;
  logic             drop;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [IdW-1:0]   mem_wid;
  logic [TimeW-1:0] mem_wdl;
  logic             fire_we;
  logic             fire_re;
  logic             tbl_re;

  assign out_free     = !out_valid_r || out_ready;
  assign issue        = (rp_r < count_r);
  assign busy         = (state_r != S_IDLE);
  assign cmd_ready    = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_fired_id = out_id_r;
  assign out_status   = out_st_r;
  assign out_last     = out_last_r;

  // Whether the entry read last cycle leaves the table.
  always_comb begin
    if (cmd_r.kind == KIND_TICK) begin
      drop = (rd_dl_r < cmd_r.now);
    end else begin
      drop = !found_r && (rd_id_r == cmd_r.id) &&
             ((cmd_r.kind != KIND_SET) || (cmd_r.id != '0));
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    sp_nxt        = sp_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = wp_r[IW-1:0];
    mem_wid       = rd_id_r;
    mem_wdl       = rd_dl_r;
    fire_we       = 1'b0;
    fire_re       = 1'b0;
    tbl_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          rp_nxt    = '0;
          wp_nxt    = '0;
          sp_nxt    = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = (cmd.kind == KIND_CLEAR) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        // Read one entry a cycle; settle the previous one.
        tbl_re   = issue;
        rp_nxt   = issue ? rp_r + 1'b1 : rp_r;
        pend_nxt = issue;
        if (pend_r) begin
          if (drop) begin
            found_nxt = 1'b1;
            if (cmd_r.kind == KIND_TICK) begin
              fire_we = 1'b1;
              sp_nxt  = sp_r + 1'b1;
            end
          end else begin
            mem_we = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          count_nxt = wp_r;
          if (cmd_r.kind != KIND_TICK) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = (sp_r == '0) ? S_IDLE : S_DRD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = cmd_r.id;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
          if (cmd_r.kind == KIND_SET) begin
            if (count_r == CW'(TABLE_DEPTH)) begin
              out_st_nxt = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_wa     = count_r[IW-1:0];
              mem_wid    = cmd_r.id;
              mem_wdl    = cmd_r.deadline;
              count_nxt  = count_r + 1'b1;
              out_st_nxt = ST_OK;
            end
          end else if (cmd_r.kind == KIND_CANCEL) begin
            out_st_nxt = found_r ? ST_REMOVED : ST_NOT_FOUND;
          end else begin
            count_nxt  = '0;
            out_st_nxt = ST_OK;
          end
        end
      end
      S_DRD: begin
        // Fired ids come back newest table position first.
        fire_re   = 1'b1;
        sp_nxt    = sp_r - 1'b1;
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = fire_rd_r;
          out_st_nxt    = ST_FIRED;
          out_last_nxt  = (sp_r == '0);
          state_nxt     = (sp_r == '0) ? S_IDLE : S_DRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      sp_r        <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      sp_r        <= sp_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_id_r   <= out_id_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_wa] <= mem_wid;
      dl_mem[mem_wa] <= mem_wdl;
    end
    if (tbl_re) begin
      rd_id_r <= id_mem[rp_r[IW-1:0]];
      rd_dl_r <= dl_mem[rp_r[IW-1:0]];
    end
  end

  // Stack of fired ids for the current tick.
  always_ff @(posedge clk) begin
    if (fire_we) begin
      fire_mem[sp_r[IW-1:0]] <= rd_id_r;
    end
    if (fire_re) begin
      fire_rd_r <= fire_mem[sp_nxt[IW-1:0]];
    end
  end

endmodule

>>> hdl/keyed_timeout_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timeout_table_unit: ordered table of pending timeouts with ids
// Set, cancel, tick and clear operations on a compacted timeout table.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_ch     in         kind, timer_id, delay_ms, now_ms
//   out_ch    out        fired_id, status, last
//
// A set or cancel scans the whole table through the memory read port, one
// entry per cycle, and then writes its result; a tick scans the table and
// then returns its fired ids one by one, and a clear skips the scan.
// A two-entry command queue lets up to two items wait while the engine works.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result channel holds the engine; intake continues until the
// queue is full.
//
module keyed_timeout_table_unit
  import ktt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ktt_in_if.sink     in_ch,
  ktt_out_if.source  out_ch
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic busy;

  ktt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_kind     (in_ch.kind),
    .in_timer_id (in_ch.timer_id),
    .in_delay_ms (in_ch.delay_ms),
    .in_now_ms   (in_ch.now_ms),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  ktt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_fired_id (out_ch.fired_id),
    .out_status   (out_ch.status),
    .out_last     (out_ch.last)
  );

  // Only fired results may be followed by more results of the same item.
  a_single_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_FIRED) |-> out_ch.last)
    else $error("non-fired result without last");

  // An accepted beat is always waiting for the engine in the next cycle.
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> cmd_valid)
    else $error("accepted beat not queued");

  // A command taken by the engine puts it to work.
  a_engine_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |=> busy)
    else $error("engine did not start on a command");

endmodule

>>> tb/keyed_timeout_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_timeout_table_unit_tb: self-checking bench of the keyed timeout table
// Drives set, cancel, tick and clear beats with random idle gaps on both
// channels, predicts every result beat from a local table model and compares
// each accepted result beat field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module keyed_timeout_table_unit_tb;
  import ktt_pkg::*;

  localparam int Depth = 16;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  status;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ktt_in_if  in_ch ();
  ktt_out_if out_ch ();

  keyed_timeout_table_unit #(.TABLE_DEPTH(Depth)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Local copy of the timeout table.
  logic [15:0] tbl_id [Depth];
  logic [47:0] tbl_deadline [Depth];
  int          tbl_count = 0;
  result_t     pending_results [$];
  int          error_count = 0;
  logic [47:0] clock_ms = 48'd1000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SET;
    in_ch.timer_id = '0;
    in_ch.delay_ms = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
  end

  // Append one expected result beat at the tail of the queue.
  function automatic void add_expected(logic [15:0] id, logic [2:0] status, logic last);
    result_t r;
    r = '{id, status, last};
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Remove the entry at pos and close the gap.
  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < tbl_count; k++) begin
      tbl_id[k] = tbl_id[k + 1];
      tbl_deadline[k] = tbl_deadline[k + 1];
    end
    tbl_count--;
  endfunction

  function automatic bit drop_by_id(logic [15:0] id);
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_id[k] == id) begin
        drop_entry(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Update the table for one beat and queue the result beats it causes.
  function automatic void predict_table(logic [1:0] kind, logic [15:0] id,
                                        logic [31:0] delay, logic [47:0] now);
    logic [48:0]  sum;
    logic [47:0]  dl;
    logic [15:0]  fired [Depth];
    int           nfired;
    int           keep;
    sum = {1'b0, now} + {17'd0, delay};
    dl = sum[48] ? TimeMax : sum[47:0];
    nfired = 0;
    case (kind)
      KIND_SET: begin
        if (id != 0) void'(drop_by_id(id));
        if (tbl_count >= Depth) begin
          add_expected(id, ST_FULL, 1'b1);
        end else begin
          tbl_id[tbl_count] = id;
          tbl_deadline[tbl_count] = dl;
          tbl_count++;
          add_expected(id, ST_OK, 1'b1);
        end
      end
      KIND_CANCEL: begin
        add_expected(id, drop_by_id(id) ? ST_REMOVED : ST_NOT_FOUND, 1'b1);
      end
      KIND_CLEAR: begin
        tbl_count = 0;
        add_expected(id, ST_OK, 1'b1);
      end
      default: begin
        keep = 0;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_deadline[k] < now) begin
            fired[nfired] = tbl_id[k];
            nfired++;
          end else begin
            tbl_id[keep] = tbl_id[k];
            tbl_deadline[keep] = tbl_deadline[k];
            keep++;
          end
        end
        tbl_count = keep;
        for (int k = nfired - 1; k >= 0; k--) begin
          add_expected(fired[k], ST_FIRED, k == 0);
        end
      end
    endcase
  endfunction

  // Send one beat after a random gap and predict its results.
  task automatic send_item(logic [1:0] kind, logic [15:0] id, logic [31:0] delay,
                           logic [47:0] now);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.timer_id <= id;
    in_ch.delay_ms <= delay;
    in_ch.now_ms <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_table(kind, id, delay, now);
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  initial begin
    int stall;
    result_t exp_r;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat id=%h status=%0d last=%0d", $time,
                 out_ch.fired_id, out_ch.status, out_ch.last);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.fired_id !== exp_r.id) begin
          $display("%0t: fired_id expected %h actual %h", $time, exp_r.id, out_ch.fired_id);
          error_count++;
        end
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_ch.status);
          error_count++;
        end
        if (out_ch.last !== exp_r.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // Extremes: deadline saturation, full table, replacement, duplicates, zero id.
  task automatic test_directed();
    send_item(KIND_SET, 16'hFFFF, 32'hFFFF_FFFF, TimeMax - 48'd5);
    send_item(KIND_SET, 16'd0, 32'd0, 48'd0);
    send_item(KIND_TICK, 16'd0, 32'd0, TimeMax);
    send_item(KIND_TICK, 16'd0, 32'd0, 48'd5);
    for (int k = 0; k < Depth; k++) send_item(KIND_SET, k[15:0] + 16'd1, k, 48'd100);
    send_item(KIND_SET, 16'd77, 32'd1, 48'd100);
    send_item(KIND_SET, 16'd3, 32'd50, 48'd100);
    send_item(KIND_CANCEL, 16'd0, 32'hFFFF_FFFF, 48'd100);
    send_item(KIND_TICK, 16'hFFFF, 32'd0, 48'd110);
    send_item(KIND_TICK, 16'd0, 32'd0, 48'd110);
    send_item(KIND_CLEAR, 16'hA5A5, 32'd0, 48'd200);
    send_item(KIND_CANCEL, 16'd1, 32'd0, 48'd200);
  endtask

  // Weighted random traffic with the time mostly rising.
  task automatic test_random(int n);
    logic [1:0]  kind;
    logic [31:0] delay;
    int          sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      kind = sel < 50 ? KIND_SET : sel < 70 ? KIND_CANCEL : sel < 97 ? KIND_TICK : KIND_CLEAR;
      delay = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 60);
      if ($urandom_range(0, 30) == 0) clock_ms = 48'({$urandom, $urandom});
      else clock_ms = clock_ms + 48'($urandom_range(0, 15));
      send_item(kind, pick_id(), delay, clock_ms);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(292);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/ktt_pkg.sv
hdl/ktt_ifs.sv
hdl/ktt_front.sv
hdl/ktt_engine.sv
hdl/keyed_timeout_table_unit.sv
tb/keyed_timeout_table_unit_tb.sv
